// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define URZD_ASSERT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("urzd: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define URZD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("urzd: next-cycle check failed");

`endif

// ===== rtl/urzd_pkg.sv =====
package urzd_pkg;

   // Payload widths
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 24;
   localparam int DIST_W      = 17;
   localparam int ZONE_W      = 3;
   localparam int TICK_W      = 4;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   // Sensor timing, in ticks
   localparam logic [TICK_W-1:0] SETTLE_TICKS     = 4'd2;
   localparam logic [TICK_W-1:0] TRIG_PULSE_TICKS = 4'd10;

   // Zone boundaries
   localparam int                NUM_BOUNDARY_REGS = 6;
   localparam logic [ZONE_W-1:0] MAX_BOUNDARIES    = 3'd6;
   localparam logic [DIST_W-1:0] DIST_MAX          = 17'd131071;

   // Register map: indexes below REG_BOUNDARIES_USED are the boundary registers
   localparam logic [2:0] REG_BOUNDARIES_USED = 3'd6;
   localparam logic [2:0] USED_RESET          = 3'd2;

   // Result item, first field in the highest bits
   typedef struct packed {
      logic                    play_start;
      logic [ZONE_W-1:0]       zone;
      logic [DIST_W-1:0]       distance;
      logic                    measure_done;
      logic                    busy_res;
      logic                    trigger_level;
   } result_type;

endpackage

// ===== rtl/ultrasonic_range_zone_detector_unit.sv =====
// Ultrasonic ranging controller with distance zone classification.
// req_ channel: one item per 1 us tick, carrying the start request and the
// sampled echo pin. rsp_ channel: exactly one result item per request item,
// in order: trigger pin level, busy, done flag, distance (0.01 cm), zone and
// a play pulse when a new nonzero zone is entered.
// A start taken while idle holds the trigger low for 2 ticks, high for 10,
// then waits (no timeout) for the echo; its high time is counted and the
// distance width*17/10 is kept up as a running quotient and remainder, so
// the done tick only compares it against the boundary registers.
// Each request item is held in the input register and its result in the
// result register, which drives the rsp_ channel.
// Throughput: one item per cycle when not stalled, set by the single state update stage.
// When rsp_tready is low the result register holds and one further item
// waits in the input register; after that req_tready drops.
// Reset (synchronous, active high) clears the pipeline, returns the
// sequencer to idle, clears the last zone and sets the boundary registers
// to 0 and boundaries_used to 2. Boundaries must be written over the csr_ port
// only while the block is idle; the block itself does not enforce this.
module ultrasonic_range_zone_detector_unit #(
   parameter int WIDTH_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // request items
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [urzd_pkg::REQ_TDATA_W-1:0]  req_tdata,  // [0] start_request, [1] echo_level
   // result items
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] trigger_level, [1] busy_res, [2] measure_done, [19:3] distance,
   // [22:20] zone, [23] play_start
   output logic [urzd_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [urzd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [urzd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [urzd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = '1;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SETTLE,
      PH_TRIG,
      PH_WAIT,
      PH_MEASURE
   } phase_type;

   // Configuration registers
   logic [urzd_pkg::DIST_W-1:0] boundary_ff [urzd_pkg::NUM_BOUNDARY_REGS];
   logic [2:0]                  used_ff;
   logic [2:0]                  csr_index;
   logic                        csr_wr;

   // Input register
   logic in_valid_ff;
   logic in_start_ff;
   logic in_echo_ff;

   // Sequencer state and result register
   phase_type                         phase_ff, phase_in;
   logic [urzd_pkg::TICK_W-1:0]       ticks_ff, ticks_in;
   logic [WIDTH_BITS-1:0]             width_ff, width_in;
   logic [urzd_pkg::DIST_W-1:0]       dist_q_ff, dist_q_in;
   logic [3:0]                        dist_r_ff, dist_r_in;
   logic [urzd_pkg::ZONE_W-1:0]       last_zone_ff, last_zone_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   urzd_pkg::result_type              rsp_data_ff, rsp_data_in;

   logic                              advance;
   logic                              fire;
   logic [urzd_pkg::TICK_W-1:0]       ticks_inc;
   logic [4:0]                        r_sum;
   logic                              r_carry;
   logic [urzd_pkg::DIST_W:0]         q_sum;
   logic [urzd_pkg::ZONE_W-1:0]       used_eff;
   logic [urzd_pkg::ZONE_W-1:0]       zone_hit;

   // Handshake: result register drains or is empty, then the stage moves
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < urzd_pkg::NUM_BOUNDARY_REGS; i++) begin
            boundary_ff[i] <= '0;
         end
         used_ff <= urzd_pkg::USED_RESET;
      end else if (csr_wr) begin
         if (csr_index < urzd_pkg::REG_BOUNDARIES_USED) begin
            boundary_ff[csr_index] <= csr_pwdata[urzd_pkg::DIST_W-1:0];
         end else if (csr_index == urzd_pkg::REG_BOUNDARIES_USED) begin
            used_ff <= csr_pwdata[2:0];
         end
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_index < urzd_pkg::REG_BOUNDARIES_USED) begin
         csr_prdata = {{(urzd_pkg::CSR_DATA_W - urzd_pkg::DIST_W){1'b0}},
                       boundary_ff[csr_index]};
      end else if (csr_index == urzd_pkg::REG_BOUNDARIES_USED) begin
         csr_prdata = {{(urzd_pkg::CSR_DATA_W - 3){1'b0}}, used_ff};
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_start_ff <= req_tdata[0];
         in_echo_ff  <= req_tdata[1];
      end
   end

   // Running distance: each echo tick adds 1.7, kept as quotient and tenths
   assign ticks_inc = ticks_ff + 1'b1;
   assign r_sum     = {1'b0, dist_r_ff} + 5'd7;
   assign r_carry   = (r_sum >= 5'd10);
   assign q_sum     = {1'b0, dist_q_ff} + {{urzd_pkg::DIST_W{1'b0}}, 1'b1}
                      + {{urzd_pkg::DIST_W{1'b0}}, r_carry};

   // Zone lookup on the current distance, lowest matching zone wins
   always_comb begin
      used_eff = (used_ff > urzd_pkg::MAX_BOUNDARIES) ? urzd_pkg::MAX_BOUNDARIES : used_ff;
      zone_hit = '0;
      for (int i = urzd_pkg::NUM_BOUNDARY_REGS - 2; i >= 0; i--) begin
         if ((urzd_pkg::ZONE_W'(i + 1) < used_eff) &&
             (dist_q_ff >= boundary_ff[i]) && (dist_q_ff < boundary_ff[i + 1])) begin
            zone_hit = urzd_pkg::ZONE_W'(i + 1);
         end
      end
   end

   // Sequencer next state and result
   always_comb begin
      phase_in     = phase_ff;
      ticks_in     = ticks_ff;
      width_in     = width_ff;
      dist_q_in    = dist_q_ff;
      dist_r_in    = dist_r_ff;
      last_zone_in = last_zone_ff;
      rsp_data_in  = '0;

      case (phase_ff)
         PH_IDLE: begin
            if (in_start_ff) begin
               phase_in = PH_SETTLE;
               ticks_in = '0;
            end
         end
         PH_SETTLE: begin
            ticks_in = ticks_inc;
            if (ticks_inc >= urzd_pkg::SETTLE_TICKS) begin
               phase_in = PH_TRIG;
               ticks_in = '0;
            end
         end
         PH_TRIG: begin
            rsp_data_in.trigger_level = 1'b1;
            ticks_in = ticks_inc;
            if (ticks_inc >= urzd_pkg::TRIG_PULSE_TICKS) begin
               phase_in = PH_WAIT;
               ticks_in = '0;
            end
         end
         PH_WAIT: begin
            if (in_echo_ff) begin
               phase_in  = PH_MEASURE;
               width_in  = {{(WIDTH_BITS - 1){1'b0}}, 1'b1};
               dist_q_in = {{(urzd_pkg::DIST_W - 1){1'b0}}, 1'b1};
               dist_r_in = 4'd7;
            end
         end
         PH_MEASURE: begin
            if (in_echo_ff) begin
               if (width_ff != WIDTH_MAX) begin
                  width_in  = width_ff + 1'b1;
                  dist_r_in = r_carry ? 4'(r_sum - 5'd10) : r_sum[3:0];
                  dist_q_in = (q_sum > {1'b0, urzd_pkg::DIST_MAX}) ?
                              urzd_pkg::DIST_MAX : q_sum[urzd_pkg::DIST_W-1:0];
               end
            end else begin
               phase_in                 = PH_IDLE;
               rsp_data_in.measure_done = 1'b1;
               rsp_data_in.distance     = dist_q_ff;
               rsp_data_in.zone         = zone_hit;
               last_zone_in             = zone_hit;
               rsp_data_in.play_start   = (zone_hit != '0) && (zone_hit != last_zone_ff);
            end
         end
         default: begin
            phase_in = PH_IDLE;
            ticks_in = '0;
         end
      endcase

      rsp_data_in.busy_res = (phase_in != PH_IDLE);
      rsp_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   // State and result register, updated once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         ticks_ff     <= '0;
         width_ff     <= '0;
         dist_q_ff    <= '0;
         dist_r_ff    <= '0;
         last_zone_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            phase_ff     <= phase_in;
            ticks_ff     <= ticks_in;
            width_ff     <= width_in;
            dist_q_ff    <= dist_q_in;
            dist_r_ff    <= dist_r_in;
            last_zone_ff <= last_zone_in;
         end
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== rtl/urzd_checker.sv =====
`include "assert_macros.svh"

module urzd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [urzd_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   urzd_pkg::result_type rsp_s;

   assign rsp_s = rsp_tdata;

   // Done tick ends the measurement
   `URZD_ASSERT(a_done_not_busy, clock, reset, rsp_tvalid && rsp_s.measure_done, !rsp_s.busy_res)

   // Trigger only driven inside a measurement
   `URZD_ASSERT(a_trig_busy, clock, reset, rsp_tvalid && rsp_s.trigger_level, rsp_s.busy_res)

   // Measurement fields are zero away from the done tick
   `URZD_ASSERT(a_idle_fields, clock, reset, rsp_tvalid && !rsp_s.measure_done, (rsp_s.distance == '0) && (rsp_s.zone == '0) && !rsp_s.play_start)

   // Play pulse only for a real zone
   `URZD_ASSERT(a_play_zone, clock, reset, rsp_tvalid && rsp_s.play_start, rsp_s.zone != '0)

   // Stalled result item holds
   `URZD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind ultrasonic_range_zone_detector_unit urzd_checker u_urzd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== dv/tb_ultrasonic_range_zone_detector_unit.sv =====
`timescale 1ns / 100ps

module tb_ultrasonic_range_zone_detector_unit;

   localparam int          ECHO_W      = 16;
   localparam int          CYCLE_LIMIT = 3_000_000;
   // register index past the end of the map, writes must be dropped
   localparam logic [2:0]  REG_SPARE   = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETTLE,
      ST_TRIG,
      ST_WAIT,
      ST_MEASURE
   } ranging_state_type;

   logic                                 clock       = 1'b0;
   logic                                 reset       = 1'b1;
   logic                                 req_tvalid  = 1'b0;
   logic                                 req_tready;
   logic [urzd_pkg::REQ_TDATA_W-1:0]     req_tdata   = '0;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready  = 1'b0;
   logic [urzd_pkg::RSP_TDATA_W-1:0]     rsp_tdata;
   logic                                 csr_psel    = 1'b0;
   logic                                 csr_penable = 1'b0;
   logic                                 csr_pwrite  = 1'b0;
   logic [urzd_pkg::CSR_ADDR_W-1:0]      csr_paddr   = '0;
   logic [urzd_pkg::CSR_DATA_W-1:0]      csr_pwdata  = '0;
   logic [urzd_pkg::CSR_DATA_W-1:0]      csr_prdata;
   logic                                 csr_pready;

   // predictor state and its copy of the registers
   ranging_state_type                    seq_phase;
   logic [urzd_pkg::TICK_W-1:0]          seq_ticks;
   logic [ECHO_W-1:0]                    echo_count;
   logic [urzd_pkg::ZONE_W-1:0]          prev_zone;
   logic [urzd_pkg::DIST_W-1:0]          bound_val [urzd_pkg::NUM_BOUNDARY_REGS];
   logic [2:0]                           bound_count;

   urzd_pkg::result_type                 expected_results [$];

   int                      error_count   = 0;
   int                      ticks_sent    = 0;
   int                      results_seen  = 0;
   int                      done_seen     = 0;
   int                      play_seen     = 0;
   int                      reg_writes    = 0;
   int                      burst_left    = 20;
   int                      cycle_count   = 0;
   int                      stall_mode    = 0;
   int                      mode_left     = 0;
   int                      stall_left    = 0;

   ultrasonic_range_zone_detector_unit #(
      .WIDTH_BITS (ECHO_W)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run-away guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  expected_results.size());
         $display("tb_ultrasonic_range_zone_detector_unit: errors");
         $finish;
      end
   end

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got)
         report_error($sformatf("result %0d %s: expected %0d, got %0d",
                                results_seen, name, want, got));
   endtask

   // zone lookup: lowest index whose window holds the distance wins
   function automatic logic [urzd_pkg::ZONE_W-1:0] zone_of(
         input logic [urzd_pkg::DIST_W-1:0] d);
      int n;
      n = (bound_count > urzd_pkg::MAX_BOUNDARIES) ? int'(urzd_pkg::MAX_BOUNDARIES)
                                                   : int'(bound_count);
      for (int i = 0; i + 1 < n; i++)
         if (d >= bound_val[i] && d < bound_val[i+1])
            return urzd_pkg::ZONE_W'(i + 1);
      return '0;
   endfunction

   task automatic clear_model();
      seq_phase   = ST_IDLE;
      seq_ticks   = '0;
      echo_count  = '0;
      prev_zone   = '0;
      bound_count = urzd_pkg::USED_RESET;
      for (int i = 0; i < urzd_pkg::NUM_BOUNDARY_REGS; i++)
         bound_val[i] = '0;
   endtask

   // one tick of the ranging sequencer; queues the result it produces
   task automatic advance_model(input logic start, input logic echo);
      urzd_pkg::result_type          r;
      logic [31:0]                   scaled;
      logic [urzd_pkg::ZONE_W-1:0]   z;
      r = '0;
      case (seq_phase)
         ST_IDLE: begin
            if (start) begin
               seq_phase = ST_SETTLE;
               seq_ticks = '0;
            end
         end
         ST_SETTLE: begin
            seq_ticks = seq_ticks + 1'b1;
            if (seq_ticks >= urzd_pkg::SETTLE_TICKS) begin
               seq_phase = ST_TRIG;
               seq_ticks = '0;
            end
         end
         ST_TRIG: begin
            r.trigger_level = 1'b1;
            seq_ticks = seq_ticks + 1'b1;
            if (seq_ticks >= urzd_pkg::TRIG_PULSE_TICKS) begin
               seq_phase = ST_WAIT;
               seq_ticks = '0;
            end
         end
         ST_WAIT: begin
            if (echo) begin
               echo_count = ECHO_W'(1);
               seq_phase  = ST_MEASURE;
            end
         end
         ST_MEASURE: begin
            if (echo) begin
               if (echo_count != '1)
                  echo_count = echo_count + 1'b1;
            end else begin
               // width * 17 / 10 hundredths of a cm
               scaled = (32'(echo_count) * 32'd17) / 32'd10;
               r.distance = (scaled > 32'(urzd_pkg::DIST_MAX)) ? urzd_pkg::DIST_MAX
                                                               : scaled[urzd_pkg::DIST_W-1:0];
               r.measure_done = 1'b1;
               z = zone_of(r.distance);
               r.zone = z;
               if (z == '0) begin
                  prev_zone = '0;
               end else begin
                  r.play_start = (z != prev_zone);
                  prev_zone = z;
               end
               seq_phase = ST_IDLE;
            end
         end
         default: begin
            seq_phase = ST_IDLE;
            seq_ticks = '0;
         end
      endcase
      r.busy_res = (seq_phase != ST_IDLE);
      expected_results = {expected_results, r};
   endtask

   // one tick item; sender runs in bursts with random gaps
   task automatic send_item(input logic start, input logic echo);
      req_tvalid <= 1'b1;
      req_tdata  <= urzd_pkg::REQ_TDATA_W'({echo, start});
      do @(posedge clock); while (!req_tready);
      advance_model(start, echo);
      ticks_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
      end
   endtask

   task automatic idle_ticks(input int n);
      repeat (n) send_item(1'b0, 1'($urandom_range(0, 1)));
   endtask

   // full measurement: start, settle, trigger, echo wait, echo high, echo fall.
   // noisy keeps start high on every busy tick and the echo high during the
   // settle and trigger ticks.
   task automatic run_ranging(input int echo_ticks, input int wait_ticks, input bit noisy);
      send_item(1'b1, noisy ? 1'b1 : 1'($urandom_range(0, 1)));
      repeat (int'(urzd_pkg::SETTLE_TICKS) + int'(urzd_pkg::TRIG_PULSE_TICKS))
         send_item(noisy | 1'($urandom_range(0, 1)), noisy | 1'($urandom_range(0, 1)));
      repeat (wait_ticks) send_item(noisy | 1'($urandom_range(0, 1)), 1'b0);
      repeat (echo_ticks) send_item(noisy | 1'($urandom_range(0, 1)), 1'b1);
      send_item(noisy | 1'($urandom_range(0, 1)), 1'b0);
   endtask

   // stop sending and let every queued result come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // register write: setup cycle, then access cycle until pready
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= urzd_pkg::CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      if (idx < urzd_pkg::REG_BOUNDARIES_USED)
         bound_val[idx] = value[urzd_pkg::DIST_W-1:0];
      else if (idx == urzd_pkg::REG_BOUNDARIES_USED)
         bound_count = value[2:0];
      reg_writes++;
   endtask

   // receiver: stall pattern that switches at random between no stalls, short stalls and long stalls
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         mode_left  <= $urandom_range(50, 500);
      end else begin
         mode_left <= mode_left - 1;
      end
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_mode != 0 && $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, (stall_mode == 2) ? 7 : 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare each result with the oldest expectation
   always @(posedge clock) begin : check_results
      urzd_pkg::result_type got;
      urzd_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = urzd_pkg::result_type'(rsp_tdata);
         if (expected_results.size() == 0) begin
            report_error($sformatf("unexpected result 0x%06h", rsp_tdata));
         end else begin
            want = expected_results.pop_front();
            check_field("trigger_level", 32'(want.trigger_level), 32'(got.trigger_level));
            check_field("busy_res",      32'(want.busy_res),      32'(got.busy_res));
            check_field("measure_done",  32'(want.measure_done),  32'(got.measure_done));
            check_field("distance",      32'(want.distance),      32'(got.distance));
            check_field("zone",          32'(want.zone),          32'(got.zone));
            check_field("play_start",    32'(want.play_start),    32'(got.play_start));
            if (want.measure_done) done_seen++;
            if (want.play_start) play_seen++;
         end
         results_seen++;
      end
   end

   // idle echo, starts while busy, echo during settle and trigger
   task automatic test_ignored_inputs();
      idle_ticks(2);
      run_ranging(1, 2, 1'b1);
      send_item(1'b0, 1'b0);
      drain();
   endtask

   // long echo, then the same zone again
   task automatic test_long_echo();
      write_reg(3'd0, 32'd0);
      write_reg(3'd1, 32'h1FFFF);
      write_reg(urzd_pkg::REG_BOUNDARIES_USED, 32'd2);
      run_ranging(120, 3, 1'b0);
      run_ranging(5, 0, 1'b0);
      drain();
   endtask

   // walk through every zone with six ascending boundaries
   task automatic test_zone_walk();
      int widths [10] = '{3, 6, 18, 18, 30, 42, 53, 65, 53, 1};
      write_reg(3'd0, 32'd10);
      write_reg(3'd1, 32'd30);
      write_reg(3'd2, 32'd50);
      write_reg(3'd3, 32'd70);
      write_reg(3'd4, 32'd90);
      write_reg(3'd5, 32'd110);
      write_reg(urzd_pkg::REG_BOUNDARIES_USED, 32'd6);
      foreach (widths[i]) run_ranging(widths[i], $urandom_range(0, 4), 1'b0);
      drain();
   endtask

   // boundary counts below two, above the maximum, unordered edges, spare index
   task automatic test_boundary_count();
      write_reg(3'd0, 32'd100);
      write_reg(3'd1, 32'd20);
      write_reg(3'd2, 32'd60);
      write_reg(3'd3, 32'd0);
      write_reg(3'd4, 32'd80);
      write_reg(3'd5, 32'd40);
      write_reg(REG_SPARE, 32'hFFFF_FFFF);
      for (int n = 0; n < 8; n++) begin
         write_reg(urzd_pkg::REG_BOUNDARIES_USED, 32'(n));
         run_ranging(15, 1, 1'b0);
         run_ranging(50, 0, 1'b0);
         drain();
      end
   endtask

   // random register settings, each followed by a stream of measurements
   task automatic test_random_rounds();
      int target;
      int round_end;
      int edge_val;
      target = ticks_sent + 200;
      while (ticks_sent < target) begin
         edge_val = 0;
         for (int i = 0; i < urzd_pkg::NUM_BOUNDARY_REGS; i++) begin
            case ($urandom_range(0, 9))
               7, 8: edge_val = $urandom_range(0, 150);
               9: edge_val = $urandom & 32'h1FFFF;
               default: edge_val = (edge_val & 16'hFFFF) + $urandom_range(0, 40);
            endcase
            write_reg(3'(i), 32'(edge_val));
         end
         write_reg(urzd_pkg::REG_BOUNDARIES_USED,
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                               : $urandom_range(2, 6));
         round_end = ticks_sent + 150;
         while (ticks_sent < round_end && ticks_sent < target) begin
            if ($urandom_range(0, 3) == 0)
               idle_ticks($urandom_range(1, 4));
            run_ranging(($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                    : $urandom_range(1, 90),
                        $urandom_range(0, 20), $urandom_range(0, 15) == 0);
         end
         drain();
      end
   endtask

   initial begin
      clear_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_ignored_inputs();
      test_long_echo();
      test_zone_walk();
      test_boundary_count();
      test_random_rounds();
      repeat (8) @(posedge clock);
      $display("Ran %0d ticks over %0d register writes: %0d results checked,", ticks_sent,
               reg_writes, results_seen);
      $display("%0d completed ranges, %0d zone entries, long echoes and stalls on both sides.",
               done_seen, play_seen);
      if (error_count == 0) begin
         $display("tb_ultrasonic_range_zone_detector_unit: clean");
      end else begin
         $display("tb_ultrasonic_range_zone_detector_unit: errors");
      end
      $finish;
   end

endmodule
